// File: sv/pkd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pkd_pkg
// Widths and field constants shared by the packed integer decoder and its
// port checker.
// ----------------------------------------------------------------------------
package pkd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned MAG_W  = 35;
	localparam int unsigned VAL_W  = MAG_W + 1;
	localparam int unsigned LEN_W  = 3;
	localparam int unsigned POS_W  = 3;

	// Byte position within a code
	localparam logic [POS_W-1:0] POS_FIRST  = 3'd0;
	localparam logic [POS_W-1:0] POS_SECOND = 3'd1;
	localparam logic [POS_W-1:0] POS_THIRD  = 3'd2;
	localparam logic [POS_W-1:0] POS_FOURTH = 3'd3;
	localparam logic [POS_W-1:0] POS_LAST   = 3'd4;

	// Code lengths
	localparam logic [LEN_W-1:0] LEN_MIN = 3'd1;
	localparam logic [LEN_W-1:0] LEN_MAX = 3'd5;

	// Magnitude bit offsets of bytes two to five
	localparam int unsigned OFS_SECOND = 6;
	localparam int unsigned OFS_THIRD  = 13;
	localparam int unsigned OFS_FOURTH = 20;
	localparam int unsigned OFS_LAST   = 27;

	// Largest magnitude a one-byte code can carry
	localparam int signed ONE_BYTE_MAX = 63;

	function automatic logic signed [VAL_W-1:0] apply_sign(
		input logic             neg,
		input logic [MAG_W-1:0] mag
	);
		logic signed [VAL_W-1:0] ext;
		ext = $signed({1'b0, mag});
		return neg ? -ext : ext;
	endfunction

endpackage
`default_nettype wire

// File: sv/packed_int_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packed_int_decoder
// Sign-magnitude variable-length integer decoder, one stream byte per
// transaction, one decoded integer per finished code.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle, back to back, whatever the code lengths,
// while no result waits untaken. Each accepted byte is merged into
// the magnitude accumulator by a single shift-and-OR; the byte that closes a
// code loads the result register directly, so a result appears on the output
// the cycle after its last byte is accepted. The first byte holds the sign
// (bit 7), a continue flag (bit 6) and magnitude bits 5..0; bytes two to four
// add 7 magnitude bits each at offsets 6, 13 and 20 with bit 7 as continue
// flag; a fifth byte adds 8 bits at offset 27 and always closes the code.
// The result is the 36-bit two's complement value and the code length 1..5;
// negative zero comes out as 0. The single result register is the only
// buffer: the input stalls only while a result waits and result_ready is low.
// ----------------------------------------------------------------------------
module packed_int_decoder (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  code_valid,
	output logic                                 code_ready,
	input  wire  [pkd_pkg::BYTE_W-1:0]           code_byte,
	output logic                                 result_valid,
	input  wire                                  result_ready,
	output logic signed [pkd_pkg::VAL_W-1:0]     decoded_value,
	output logic [pkd_pkg::LEN_W-1:0]            code_length
);
	import pkd_pkg::*;

	// Decode state
	logic [MAG_W-1:0] mag_acc_q;
	logic             neg_q;
	logic [POS_W-1:0] pos_q;

	// Result register
	logic                    res_valid_q;
	logic signed [VAL_W-1:0] res_value_q;
	logic [LEN_W-1:0]        res_len_q;

	logic             accept;
	logic             is_first;
	logic             code_done;
	logic [MAG_W-1:0] mag_add;
	logic [MAG_W-1:0] mag_nxt;
	logic             neg_nxt;
	logic [POS_W-1:0] pos_inc;
	logic [LEN_W-1:0] len_nxt;

	// Take a byte whenever the result slot is free or drains this cycle
	assign code_ready = !res_valid_q || result_ready;
	assign accept     = code_valid && code_ready;

	// Treat any out-of-range position as the start of a new code
	assign is_first = (pos_q == POS_FIRST) || (pos_q > POS_LAST);
	assign pos_inc  = pos_q + POS_W'(1);

	// Place the payload bits of the current byte
	always_comb begin
		unique case (pos_q)
			POS_SECOND: mag_add = MAG_W'(code_byte[6:0]) << OFS_SECOND;
			POS_THIRD:  mag_add = MAG_W'(code_byte[6:0]) << OFS_THIRD;
			POS_FOURTH: mag_add = MAG_W'(code_byte[6:0]) << OFS_FOURTH;
			POS_LAST:   mag_add = MAG_W'(code_byte) << OFS_LAST;
			default:    mag_add = MAG_W'(code_byte[5:0]);
		endcase
	end

	always_comb begin
		if (is_first) begin
			mag_nxt   = mag_add;
			neg_nxt   = code_byte[7];
			code_done = !code_byte[6];
			len_nxt   = LEN_MIN;
		end else begin
			mag_nxt   = mag_acc_q | mag_add;
			neg_nxt   = neg_q;
			code_done = (pos_q == POS_LAST) || !code_byte[7];
			len_nxt   = LEN_W'(pos_inc);
		end
	end

	// Advance the decode state; clear it when a code closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_acc_q <= '0;
			neg_q     <= 1'b0;
			pos_q     <= POS_FIRST;
		end else if (accept) begin
			if (code_done) begin
				mag_acc_q <= '0;
				neg_q     <= 1'b0;
				pos_q     <= POS_FIRST;
			end else begin
				mag_acc_q <= mag_nxt;
				neg_q     <= neg_nxt;
				pos_q     <= is_first ? POS_SECOND : pos_inc;
			end
		end
	end

	// Hold the result until taken; load a new one when a code closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && code_done) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && code_done) begin
			res_value_q <= apply_sign(neg_nxt, mag_nxt);
			res_len_q   <= len_nxt;
		end
	end

	assign result_valid  = res_valid_q;
	assign decoded_value = res_value_q;
	assign code_length   = res_len_q;

endmodule
`default_nettype wire

// File: sv/pkd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pkd_port_checks
// Port-level checks for the packed integer decoder.
// ----------------------------------------------------------------------------
module pkd_port_checks (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  code_valid,
	input wire                                  code_ready,
	input wire                                  result_valid,
	input wire                                  result_ready,
	input wire  signed [pkd_pkg::VAL_W-1:0]     decoded_value,
	input wire  [pkd_pkg::LEN_W-1:0]            code_length
);
	import pkd_pkg::*;

	// Hold a stalled result unchanged
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(decoded_value) && $stable(code_length))
		else $error("stalled result changed or dropped");

	// Never stall the input while the result slot is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid || result_ready |-> code_ready)
		else $error("input stalled with a free result slot");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> code_length >= LEN_MIN && code_length <= LEN_MAX)
		else $error("code length out of range");

	// A one-byte code carries at most six magnitude bits
	a_one_byte_mag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && code_length == LEN_MIN |->
			decoded_value <= VAL_W'(ONE_BYTE_MAX) &&
			decoded_value >= -(VAL_W'(ONE_BYTE_MAX)))
		else $error("one-byte code with oversized magnitude");

	// A result follows only an accepted byte or a held result
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(code_valid && code_ready))
		else $error("result without an accepted byte");

endmodule

bind packed_int_decoder pkd_port_checks u_pkd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.code_valid    (code_valid),
	.code_ready    (code_ready),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.decoded_value (decoded_value),
	.code_length   (code_length)
);
`default_nettype wire
